// ----- src/tlga_pkg.sv -----
package tlga_pkg;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam logic [7:0] GBK_LEAD_BASE  = 8'h81;
  localparam logic [7:0] GBK_TRAIL_LO   = 8'h40;
  localparam logic [7:0] GBK_TRAIL_HI   = 8'h41;
  localparam logic [7:0] GBK_TRAIL_SPLIT = 8'h7f;
  localparam logic [7:0] ASCII_LAST     = 8'h7f;
  localparam logic [7:0] ASCII_SPACE    = 8'h20;
  localparam logic [31:0] GBK_ROW_LEN   = 32'd190;

  localparam logic [4:0] HEIGHT_SMALL = 5'd12;
  localparam logic [4:0] HEIGHT_LARGE = 5'd16;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_FONT_SELECT = 1'b0,
    REG_NONE        = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [4:0]  width;
    logic [4:0]  height;
  } place_req_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] next_x;
  } place_t;

endpackage

// ----- src/tlga_cursor.sv -----
module tlga_cursor #(
  parameter int SCREEN_WIDTH  = tlga_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tlga_pkg::SCREEN_HEIGHT_DEF
) (
  input  tlga_pkg::place_req_t req_i,
  output tlga_pkg::place_t     place_o
);

  localparam logic [16:0] XLim = 17'(SCREEN_WIDTH);
  localparam logic [16:0] YLim = 17'(SCREEN_HEIGHT);

  logic        wrap_x;
  logic        wrap_y;
  logic [15:0] x1;
  logic [15:0] y1;

  always_comb begin
    wrap_x = {1'b0, req_i.cur_x} > (XLim - 17'(req_i.width));
    x1     = wrap_x ? 16'd0 : req_i.cur_x;
    y1     = wrap_x ? (req_i.cur_y + 16'(req_i.height)) : req_i.cur_y;
    // A line that no longer fits brings the cursor back to the top left.
    wrap_y = {1'b0, y1} > (YLim - 17'(req_i.height));
    place_o.pos_x  = wrap_y ? 16'd0 : x1;
    place_o.pos_y  = wrap_y ? 16'd0 : y1;
    place_o.next_x = place_o.pos_x + 16'(req_i.width);
  end

endmodule

// ----- src/text_layout_glyph_addresser_top.sv -----
// A request accepted into the input register moves on into the result register;
// an output stall can hold it in the input register.
// Throughput: one text byte per cycle while the output is not stalled; the cursor wrap
// and offset logic sits between the input register and the result register.
// Reset (rst_ni low, asynchronous) clears the cursor, the pending lead byte,
// font_select and both valid flags.
module text_layout_glyph_addresser_top #(
  parameter int SCREEN_WIDTH  = tlga_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tlga_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        start_new_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_wide_o,
  output logic [31:0] glyph_offset_o,
  output logic [5:0]  glyph_bytes_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [4:0]  glyph_width_o,
  output logic [4:0]  glyph_height_o
);

  // Configuration port.
  logic                  font_q;
  tlga_pkg::reg_index_e  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = tlga_pkg::reg_index_e'(paddr[2]);

  always_comb begin
    case (reg_idx)
      tlga_pkg::REG_FONT_SELECT: prdata = {31'd0, font_q};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == tlga_pkg::REG_FONT_SELECT) begin
      font_q <= pwdata[0];
    end
  end

  // Input register.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_start_q;
  logic [15:0] s1_sx_q;
  logic [15:0] s1_sy_q;
  logic        in_accept;
  logic        s1_adv;
  logic        s1_res;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= char_byte_i;
      s1_start_q <= start_new_i;
      s1_sx_q    <= start_x_i;
      s1_sy_q    <= start_y_i;
    end
  end

  // Layout state.
  logic [15:0] cur_x_q, cur_x_d;
  logic [15:0] cur_y_q, cur_y_d;
  logic        pend_q, pend_d;
  // (lead - 0x81) * 190, computed when the lead byte arrives.
  logic [31:0] lead_base_q, lead_base_d;

  logic        pend_eff;
  logic        is_zero;
  logic        is_lead;
  logic        wide;
  logic [4:0]  height;
  logic [4:0]  width;
  logic [15:0] narrow_idx;
  logic [15:0] narrow_off;
  logic [31:0] trail_adj;
  logic [31:0] wide_idx;
  logic [31:0] wide_off;

  tlga_pkg::place_req_t preq;
  tlga_pkg::place_t     plc;

  always_comb begin
    pend_eff = s1_start_q ? 1'b0 : pend_q;
    is_zero  = (s1_byte_q == 8'd0);
    is_lead  = !pend_eff && (s1_byte_q > tlga_pkg::ASCII_LAST);
    wide     = pend_eff;
    s1_res   = !is_zero && !is_lead;

    height = font_q ? tlga_pkg::HEIGHT_LARGE : tlga_pkg::HEIGHT_SMALL;
    width  = wide ? height : (height >> 1);

    preq.cur_x  = s1_start_q ? s1_sx_q : cur_x_q;
    preq.cur_y  = s1_start_q ? s1_sy_q : cur_y_q;
    preq.width  = width;
    preq.height = height;

    narrow_idx = 16'(s1_byte_q) - 16'(tlga_pkg::ASCII_SPACE);
    narrow_off = font_q ? (narrow_idx << 4) : ((narrow_idx << 3) + (narrow_idx << 2));

    trail_adj = (s1_byte_q < tlga_pkg::GBK_TRAIL_SPLIT) ?
                (32'(s1_byte_q) - 32'(tlga_pkg::GBK_TRAIL_LO)) :
                (32'(s1_byte_q) - 32'(tlga_pkg::GBK_TRAIL_HI));
    wide_idx  = lead_base_q + trail_adj;
    wide_off  = font_q ? (wide_idx << 5) : ((wide_idx << 4) + (wide_idx << 3));

    cur_x_d     = preq.cur_x;
    cur_y_d     = preq.cur_y;
    pend_d      = pend_eff;
    lead_base_d = lead_base_q;
    if (is_zero) begin
      pend_d = 1'b0;
    end else if (is_lead) begin
      pend_d      = 1'b1;
      lead_base_d = (32'(s1_byte_q) - 32'(tlga_pkg::GBK_LEAD_BASE)) * tlga_pkg::GBK_ROW_LEN;
    end else begin
      pend_d  = 1'b0;
      cur_x_d = plc.next_x;
      cur_y_d = plc.pos_y;
    end
  end

  tlga_cursor #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_cursor (
    .req_i  (preq),
    .place_o(plc)
  );

  // A byte that places nothing moves on even while the result register is held.
  assign s1_adv = s1_valid_q && (!s1_res || !out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= 16'd0;
      cur_y_q     <= 16'd0;
      pend_q      <= 1'b0;
      lead_base_q <= 32'd0;
    end else if (s1_adv) begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      pend_q      <= pend_d;
      lead_base_q <= lead_base_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res) begin
      is_wide_o      <= wide;
      glyph_offset_o <= wide ? wide_off : {16'd0, narrow_off};
      glyph_bytes_o  <= wide ? {height, 1'b0} : {1'b0, height};
      pos_x_o        <= plc.pos_x;
      pos_y_o        <= plc.pos_y;
      glyph_width_o  <= width;
      glyph_height_o <= height;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && s1_res && out_valid_o && out_stall_i))
    else $error("result register overwritten while held");

  a_x_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, pos_x_o} + 17'(glyph_width_o)) <= 17'(SCREEN_WIDTH))
    else $error("glyph placed past right edge");

  a_y_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, pos_y_o} + 17'(glyph_height_o)) <= 17'(SCREEN_HEIGHT))
    else $error("glyph placed past bottom edge");

  a_bytes_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_wide_o ? (glyph_bytes_o == {glyph_height_o, 1'b0}) :
                                 (glyph_bytes_o == {1'b0, glyph_height_o})))
    else $error("glyph size inconsistent with kind");
`endif

endmodule

// ----- tb/tb_text_layout_glyph_addresser_top.sv -----
module tb_text_layout_glyph_addresser_top;

  localparam int SCREEN_W = tlga_pkg::SCREEN_WIDTH_DEF;
  localparam int SCREEN_H = tlga_pkg::SCREEN_HEIGHT_DEF;

  localparam logic [7:0]  END_OF_TEXT    = 8'h00;
  localparam logic [7:0]  FIRST_LEAD     = 8'h81;
  localparam logic [7:0]  TRAIL_LOW      = 8'h40;
  localparam logic [7:0]  TRAIL_HIGH     = 8'h41;
  localparam logic [7:0]  TRAIL_GAP      = 8'h7f;
  localparam logic [7:0]  LAST_ASCII     = 8'h7f;
  localparam logic [7:0]  SPACE_CHAR     = 8'h20;
  localparam logic [31:0] GBK_ROW        = 32'd190;
  localparam logic [4:0]  FONT_12_HEIGHT = 5'd12;
  localparam logic [4:0]  FONT_16_HEIGHT = 5'd16;

  localparam logic [2:0] FONT_ADDR = 3'(4 * int'(tlga_pkg::REG_FONT_SELECT));

  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        start_new;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } text_req_t;

  typedef struct packed {
    logic        is_wide;
    logic [31:0] offset;
    logic [5:0]  nbytes;
    logic [15:0] x;
    logic [15:0] y;
    logic [4:0]  w;
    logic [4:0]  h;
  } glyph_place_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte_i = '0;
  logic        start_new_i = 1'b0;
  logic [15:0] start_x_i = '0;
  logic [15:0] start_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_wide_o;
  logic [31:0] glyph_offset_o;
  logic [5:0]  glyph_bytes_o;
  logic [15:0] pos_x_o;
  logic [15:0] pos_y_o;
  logic [4:0]  glyph_width_o;
  logic [4:0]  glyph_height_o;

  text_req_t    text_reqs[$];
  glyph_place_t expected_glyphs[$];
  text_req_t    next_req;
  logic         in_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           recv_hold_left = 0;
  int           fail_count = 0;

  // Layout state as the block should hold it.
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic        lead_held = 1'b0;
  logic [7:0]  lead_val = '0;
  logic        font_big = 1'b0;

  text_layout_glyph_addresser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .start_new_i    (start_new_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_wide_o      (is_wide_o),
    .glyph_offset_o (glyph_offset_o),
    .glyph_bytes_o  (glyph_bytes_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .glyph_width_o  (glyph_width_o),
    .glyph_height_o (glyph_height_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic predict_glyph(input logic [7:0] code, input logic start_new,
                               input logic [15:0] sx, input logic [15:0] sy);
    glyph_place_t g;
    logic [4:0]   h;
    logic [31:0]  idx;
    logic [31:0]  narrow_off;
    h = font_big ? FONT_16_HEIGHT : FONT_12_HEIGHT;
    if (start_new) begin
      cur_x = sx;
      cur_y = sy;
      lead_held = 1'b0;
    end
    if (code == END_OF_TEXT) begin
      lead_held = 1'b0;
      return;
    end
    g.h = h;
    if (lead_held) begin
      idx = (32'(lead_val) - 32'(FIRST_LEAD)) * GBK_ROW;
      idx = idx + ((code < TRAIL_GAP) ? (32'(code) - 32'(TRAIL_LOW))
                                      : (32'(code) - 32'(TRAIL_HIGH)));
      g.is_wide = 1'b1;
      g.offset = idx * (32'(h) * 32'd2);
      g.nbytes = 6'(h) * 6'd2;
      g.w = h;
      lead_held = 1'b0;
    end else if (code > LAST_ASCII) begin
      lead_held = 1'b1;
      lead_val = code;
      return;
    end else begin
      narrow_off = (32'(code) - 32'(SPACE_CHAR)) * 32'(h);
      g.is_wide = 1'b0;
      g.offset = {16'h0, narrow_off[15:0]};
      g.nbytes = 6'(h);
      g.w = h >> 1;
    end
    // Wrap to the next line first, then to the top if the line does not fit.
    if (int'(cur_x) > SCREEN_W - int'(g.w)) begin
      cur_x = '0;
      cur_y = cur_y + 16'(h);
    end
    if (int'(cur_y) > SCREEN_H - int'(h)) begin
      cur_x = '0;
      cur_y = '0;
    end
    g.x = cur_x;
    g.y = cur_y;
    cur_x = cur_x + 16'(g.w);
    expected_glyphs.push_back(g);
  endtask

  task automatic check_glyph();
    glyph_place_t exp_g;
    if (expected_glyphs.size() == 0) begin
      $error("unexpected glyph: offset %0h at (%0d,%0d)", glyph_offset_o, pos_x_o, pos_y_o);
      fail_count++;
      return;
    end
    exp_g = expected_glyphs.pop_front();
    if (is_wide_o !== exp_g.is_wide) begin
      $error("is_wide: expected %0d, got %0d", exp_g.is_wide, is_wide_o);
      fail_count++;
    end
    if (glyph_offset_o !== exp_g.offset) begin
      $error("glyph_offset: expected %0h, got %0h", exp_g.offset, glyph_offset_o);
      fail_count++;
    end
    if (glyph_bytes_o !== exp_g.nbytes) begin
      $error("glyph_bytes: expected %0d, got %0d", exp_g.nbytes, glyph_bytes_o);
      fail_count++;
    end
    if (pos_x_o !== exp_g.x) begin
      $error("pos_x: expected %0d, got %0d", exp_g.x, pos_x_o);
      fail_count++;
    end
    if (pos_y_o !== exp_g.y) begin
      $error("pos_y: expected %0d, got %0d", exp_g.y, pos_y_o);
      fail_count++;
    end
    if (glyph_width_o !== exp_g.w) begin
      $error("glyph_width: expected %0d, got %0d", exp_g.w, glyph_width_o);
      fail_count++;
    end
    if (glyph_height_o !== exp_g.h) begin
      $error("glyph_height: expected %0d, got %0d", exp_g.h, glyph_height_o);
      fail_count++;
    end
  endtask

  // Accepted requests are predicted before results are checked, so a
  // result in the same cycle as its request would still find its entry.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_glyph(char_byte_i, start_new_i, start_x_i, start_y_i);
      end
      if (out_valid_o && !out_stall_i) begin
        check_glyph();
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (text_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = text_reqs.pop_front();
        char_byte_i <= next_req.char_code;
        start_new_i <= next_req.start_new;
        start_x_i <= next_req.start_x;
        start_y_i <= next_req.start_y;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (recv_hold_left > 0) begin
      out_stall_i <= 1'b1;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] code, input logic start_new,
                            input logic [15:0] sx, input logic [15:0] sy);
    text_req_t req;
    req.char_code = code;
    req.start_new = start_new;
    req.start_x = sx;
    req.start_y = sy;
    text_reqs.push_back(req);
  endtask

  // Mostly well-formed strings (start, ASCII and GBK pairs, terminator),
  // the rest single bytes of noise.
  task automatic queue_text(input int count);
    int          made;
    int          len;
    logic [15:0] sx;
    logic [15:0] sy;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 75) begin
          sx = 16'($urandom_range(250));
          sy = 16'($urandom_range(330));
        end else begin
          sx = 16'($urandom);
          sy = 16'($urandom);
        end
        len = $urandom_range(20, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 55) begin
            queue_byte(8'($urandom_range(8'h7e, 8'h20)), k == 0, sx, sy);
            made++;
          end else begin
            queue_byte(8'($urandom_range(8'hfe, 8'h81)), k == 0, sx, sy);
            queue_byte(($urandom_range(1) == 0) ? 8'($urandom_range(8'h7e, 8'h40))
                                                : 8'($urandom_range(8'hfe, 8'h80)),
                       1'b0, 16'($urandom), 16'($urandom));
            made += 2;
          end
        end
        if ($urandom_range(99) < 75) begin
          queue_byte(END_OF_TEXT, 1'b0, 16'($urandom), 16'($urandom));
          made++;
        end
      end else begin
        queue_byte(8'($urandom_range(255)), $urandom_range(99) < 15,
                   16'($urandom), 16'($urandom));
        made++;
      end
    end
  endtask

  task automatic drain_requests();
    while (text_reqs.size() != 0 || in_valid_i || expected_glyphs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_font(input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= FONT_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    font_big = value[0];
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {31'b0, font_big}) begin
      $error("font_select: expected %0h, got %0h", {31'b0, font_big}, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_font({31'($urandom_range(32'h7fff_ffff)), 1'b0});

    send_idle_pct = 36;
    recv_idle_pct = 61;
    queue_byte(8'h41, 1'b1, 16'd0, 16'd0);
    queue_byte(8'h20, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h7f, 1'b0, 16'd0, 16'd0);
    // Control characters below space give a wrapped offset.
    queue_byte(8'h01, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h1f, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h81, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h40, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hfe, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hfe, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h81, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h7f, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h81, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h7e, 1'b0, 16'd0, 16'd0);
    // A lead of 0x80 with a control trail drives the offset negative.
    queue_byte(8'h80, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h01, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hff, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hff, 1'b0, 16'd0, 16'd0);
    // A terminator in trail position drops the lead.
    queue_byte(8'h90, 1'b0, 16'd0, 16'd0);
    queue_byte(END_OF_TEXT, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h42, 1'b0, 16'd0, 16'd0);
    // A new string drops a pending lead and starts past the right edge, so it wraps.
    queue_byte(8'ha0, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h43, 1'b1, 16'd235, 16'd0);
    queue_byte(8'h41, 1'b1, 16'hffff, 16'hffff);
    queue_byte(8'hb0, 1'b1, 16'd0, 16'd310);
    queue_byte(8'ha1, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h5a, 1'b1, 16'd234, 16'd308);
    queue_byte(8'hb0, 1'b0, 16'd0, 16'd0);
    queue_byte(8'ha1, 1'b0, 16'd0, 16'd0);
    queue_byte(END_OF_TEXT, 1'b1, 16'd100, 16'd100);
    // Leave a lead pending across the font change.
    queue_byte(8'hc3, 1'b0, 16'd0, 16'd0);
    drain_requests();
    write_font(32'hffff_ffff);

    queue_byte(8'h5a, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h7e, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hd7, 1'b0, 16'd0, 16'd0);
    queue_byte(8'hf9, 1'b0, 16'd0, 16'd0);
    queue_byte(8'h30, 1'b1, 16'h8000, 16'h1234);
    queue_byte(8'h31, 1'b1, 16'd224, 16'd304);
    queue_byte(8'h32, 1'b0, 16'd0, 16'd0);
    drain_requests();

    for (int seg = 0; seg < 12; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queue_text(72);
      drain_requests();
      if (seg % 2 == 1) begin
        write_font($urandom);
      end
    end

    // The receiver holds off long enough for the block to back up its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = 300;
    queue_text(52);
    drain_requests();

    if (fail_count == 0 && expected_glyphs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
